// ===== rtl/core/sle_pkg.sv =====
// Shared types and constants of the sortable list engine.
package sle_pkg;

   // Field widths fixed by the item format.
   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;

   // Command codes carried by an input item.
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SORT_UP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SORT_DOWN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

   // Status codes carried by a result item.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Outcome of the shared signed comparator.
   typedef struct packed {
      logic eq;
      logic lt;
      logic gt;
   } cmp_res_type;

endpackage

// ===== rtl/core/sortable_list_engine.sv =====
// Top level of the sortable list engine: list memory, sequencer and result register.
//
//  Channel   Ports                                   Handshake
//  command   req_cmd, req_item_value                 taken when start is high and busy is low
//  result    rsp_status, rsp_found, rsp_position,    shown for one cycle while rsp_valid is high
//            rsp_entry_value, rsp_last
//
// The list sits in a single-port-write, single-port-read memory with registered read data,
// and search and sort steps pass the entry just read through the shared comparator.
// A read-out gives one result item per entry, with rsp_last set on the final one; each of the
// other defined commands gives a single result item; spare codes give none.
// Reset (synchronous) empties the list by clearing the entry count; the memory needs no clearing pass.
// The receiver cannot stall results, so nothing waits on the result side.
module sortable_list_engine
   import sle_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [DATA_W-1:0]   req_item_value,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [POS_W-1:0]           rsp_position,
   output logic signed [DATA_W-1:0]   rsp_entry_value,
   output logic                       rsp_last
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE      = CW'(1);
   localparam logic [CW-1:0] TWO      = CW'(2);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_SHIFT_RD = 13'b0000000000010,
      ST_SHIFT_WR = 13'b0000000000100,
      ST_INS_HEAD = 13'b0000000001000,
      ST_SRCH_RD  = 13'b0000000010000,
      ST_SRCH_CMP = 13'b0000000100000,
      ST_SORT_KEY = 13'b0000001000000,
      ST_SORT_LDK = 13'b0000010000000,
      ST_SORT_PRV = 13'b0000100000000,
      ST_SORT_CMP = 13'b0001000000000,
      ST_SORT_PUT = 13'b0010000000000,
      ST_READ_RD  = 13'b0100000000000,
      ST_READ_OUT = 13'b1000000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           i_ff, i_in;
   logic [CW-1:0]           j_ff, j_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic                    desc_ff, desc_in;

   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic [IW-1:0]           rd_addr;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_position_ff, rsp_position_in;
   logic signed [DATA_W-1:0] rsp_entry_value_ff, rsp_entry_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [CW-1:0]           i_plus;
   logic [CW-1:0]           j_minus;
   logic [CW+POS_W-1:0]     pos_wide;
   logic                    move;
   cmp_res_type             cmp_res;

   // Shared comparator: the entry just read against the search key or the sort key.
   sle_cmp u_cmp (
      .op_a (rd_data_ff),
      .op_b (key_ff),
      .res  (cmp_res)
   );

   assign i_plus   = i_ff + ONE;
   assign j_minus  = j_ff - ONE;
   assign pos_wide = {{POS_W{1'b0}}, i_plus};
   assign move     = desc_ff ? cmp_res.lt : cmp_res.gt;

   // Sequencer: one memory access per cycle, results built into the output register.
   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      i_in               = i_ff;
      j_in               = j_ff;
      key_in             = key_ff;
      desc_in            = desc_ff;
      rd_addr            = '0;
      wr_en              = 1'b0;
      wr_addr            = '0;
      wr_data            = key_ff;
      rsp_valid_in       = 1'b0;
      rsp_status_in      = STATUS_OK;
      rsp_found_in       = 1'b0;
      rsp_position_in    = '0;
      rsp_entry_value_in = '0;
      rsp_last_in        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = req_item_value;
               i_in   = '0;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     if (cnt_ff == FULL_CNT) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else if (cnt_ff == '0) begin
                        state_in = ST_INS_HEAD;
                     end else begin
                        j_in     = cnt_ff;
                        state_in = ST_SHIFT_RD;
                     end
                  end
                  CMD_SEARCH: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SRCH_RD;
                     end
                  end
                  CMD_SORT_UP, CMD_SORT_DOWN: begin
                     desc_in = (req_cmd == CMD_SORT_DOWN);
                     if (cnt_ff < TWO) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        i_in     = ONE;
                        state_in = ST_SORT_KEY;
                     end
                  end
                  CMD_READ: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_READ_RD;
                     end
                  end
                  CMD_CLEAR: begin
                     cnt_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Insert: move each entry one place toward the tail, last entry first.
         ST_SHIFT_RD: begin
            rd_addr  = j_minus[IW-1:0];
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[IW-1:0];
            wr_data  = rd_data_ff;
            j_in     = j_minus;
            state_in = (j_ff == ONE) ? ST_INS_HEAD : ST_SHIFT_RD;
         end
         ST_INS_HEAD: begin
            wr_en        = 1'b1;
            wr_addr      = '0;
            wr_data      = key_ff;
            cnt_in       = cnt_ff + ONE;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         // Search: compare entries from the head until the first match or the end of the list.
         ST_SRCH_RD: begin
            rd_addr  = i_ff[IW-1:0];
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (cmp_res.eq) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = pos_wide[POS_W-1:0];
               state_in        = ST_IDLE;
            end else if (i_plus == cnt_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               i_in     = i_plus;
               state_in = ST_SRCH_RD;
            end
         end

         // Sort: take entry i as the key and walk it toward the head.
         ST_SORT_KEY: begin
            rd_addr  = i_ff[IW-1:0];
            state_in = ST_SORT_LDK;
         end
         ST_SORT_LDK: begin
            key_in   = rd_data_ff;
            j_in     = i_ff;
            state_in = ST_SORT_PRV;
         end
         ST_SORT_PRV: begin
            rd_addr  = j_minus[IW-1:0];
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IW-1:0];
            if (move) begin
               wr_data  = rd_data_ff;
               j_in     = j_minus;
               state_in = (j_ff == ONE) ? ST_SORT_PUT : ST_SORT_PRV;
            end else begin
               wr_data = key_ff;
               if (i_plus == cnt_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  i_in     = i_plus;
                  state_in = ST_SORT_KEY;
               end
            end
         end
         ST_SORT_PUT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IW-1:0];
            wr_data = key_ff;
            if (i_plus == cnt_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               i_in     = i_plus;
               state_in = ST_SORT_KEY;
            end
         end

         // Read out: one result item per entry, from the head.
         ST_READ_RD: begin
            rd_addr  = i_ff[IW-1:0];
            state_in = ST_READ_OUT;
         end
         ST_READ_OUT: begin
            rsp_valid_in       = 1'b1;
            rsp_entry_value_in = rd_data_ff;
            rsp_last_in        = (i_plus == cnt_ff);
            if (i_plus == cnt_ff) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_plus;
               state_in = ST_READ_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // List memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   // Control state is reset; working and payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff               <= i_in;
      j_ff               <= j_in;
      key_ff             <= key_in;
      desc_ff            <= desc_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_position_ff    <= rsp_position_in;
      rsp_entry_value_ff <= rsp_entry_value_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_value = rsp_entry_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== rtl/core/sle_cmp.sv =====
// Shared signed comparator used by the search and sort sequences.
module sle_cmp
   import sle_pkg::*;
(
   input  logic signed [DATA_W-1:0] op_a,
   input  logic signed [DATA_W-1:0] op_b,
   output cmp_res_type              res
);

   // Separate compares give equality, less-than and greater-than.
   always_comb begin
      res.eq = (op_a == op_b);
      res.lt = (op_a < op_b);
      res.gt = (op_a > op_b);
   end

endmodule

// ===== rtl/core/sle_checker.sv =====
// Port-level checks of the sortable list engine and the bind that attaches them.
module sle_checker
   import sle_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_valid,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic                     rsp_found,
   input logic [POS_W-1:0]         rsp_position,
   input logic signed [DATA_W-1:0] rsp_entry_value,
   input logic                     rsp_last
);

   // A full or empty status is always a lone item with no search or read-out data.
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         rsp_last && !rsp_found && (rsp_position == '0) && (rsp_entry_value == '0))
      else $error("error status item carries data or is not last");

   // A search hit is the single, final item of its command.
   a_found_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_last && (rsp_entry_value == '0))
      else $error("search hit is not a lone final item");

   // More items are still to come, so the engine must still be working.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final item while the engine is idle");

   // An idle engine with no new command produces nothing.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !rsp_valid)
      else $error("result item without a command");

endmodule

bind sortable_list_engine sle_checker u_sle_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found       (rsp_found),
   .rsp_position    (rsp_position),
   .rsp_entry_value (rsp_entry_value),
   .rsp_last        (rsp_last)
);

// ===== tb/sortable_list_engine_tb.sv =====
// Self-checking testbench for the sortable list engine: command stimulus, list predictor, checker.
`timescale 1ns / 1ps

module sortable_list_engine_tb;
   import sle_pkg::*;

   localparam int LIST_DEPTH    = 16;
   localparam int RANDOM_ITEMS  = 120;
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int REPORT_LIMIT  = 10;

   // Command codes the block must ignore.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
      int unsigned              gap_after;
      bit                       drain_before;
   } list_command_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] entry_value;
      logic                     last;
   } list_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [CMD_W-1:0]           req_cmd = '0;
   logic signed [DATA_W-1:0]   req_item_value = '0;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_found;
   logic [POS_W-1:0]           rsp_position;
   logic signed [DATA_W-1:0]   rsp_entry_value;
   logic                       rsp_last;

   // Stimulus and expectation stores.
   list_command_type           commands_to_send[$];
   list_result_type            results_due[$];
   logic signed [DATA_W-1:0]   inserted_values[$];

   // Shadow copy of the list held by the block.
   logic signed [DATA_W-1:0]   shadow_list[LIST_DEPTH];
   int unsigned                shadow_count = 0;

   int unsigned                send_wait = 0;
   int unsigned                error_count = 0;
   int unsigned                cycle_count = 0;
   int unsigned                random_items = 0;
   bit                         burst_mode = 1'b0;
   bit                         drain_next = 1'b0;

   sortable_list_engine #(.DEPTH(LIST_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   // Apply one accepted command to the shadow list and queue the results it must produce.
   function automatic void apply_list_command(input logic [CMD_W-1:0] cmd,
                                              input logic signed [DATA_W-1:0] value);
      list_result_type          res;
      logic signed [DATA_W-1:0] key;
      int                       i;
      int                       j;
      bit                       hit;
      bit                       descending;
      res = '{status: STATUS_OK, found: 1'b0, position: '0, entry_value: '0, last: 1'b1};
      case (cmd)
         CMD_INSERT: begin
            if (shadow_count >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[0] = value;
               shadow_count++;
            end
            results_due.push_back(res);
         end
         CMD_SEARCH: begin
            hit = 1'b0;
            for (i = 0; i < shadow_count; i++) begin
               if (!hit && shadow_list[i] == value) begin
                  hit = 1'b1;
                  res.found = 1'b1;
                  res.position = POS_W'(i + 1);
               end
            end
            results_due.push_back(res);
         end
         CMD_SORT_UP, CMD_SORT_DOWN: begin
            // Insertion sort; equal values cannot be told apart, so stability is irrelevant.
            descending = (cmd == CMD_SORT_DOWN);
            for (i = 1; i < shadow_count; i++) begin
               key = shadow_list[i];
               j = i;
               while (j > 0 && (descending ? (shadow_list[j-1] < key)
                                           : (shadow_list[j-1] > key))) begin
                  shadow_list[j] = shadow_list[j-1];
                  j--;
               end
               shadow_list[j] = key;
            end
            results_due.push_back(res);
         end
         CMD_READ: begin
            if (shadow_count == 0) begin
               res.status = STATUS_EMPTY;
               results_due.push_back(res);
            end else begin
               for (i = 0; i < shadow_count; i++) begin
                  res.entry_value = shadow_list[i];
                  res.last = (i == shadow_count - 1);
                  results_due.push_back(res);
               end
            end
         end
         CMD_CLEAR: begin
            shadow_count = 0;
            results_due.push_back(res);
         end
         default: begin
            // Spare codes leave the list alone and give no result.
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want_v,
                                  input logic [DATA_W-1:0] got_v);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("MISMATCH %s: expected %0h, got %0h", what, want_v, got_v);
   endtask

   // Pick a value with a bias toward extremes and small numbers, so duplicates occur.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return $urandom_range(0, 1) ? '0 : '1;
         3, 4, 5: return DATA_W'($signed($urandom_range(0, 15)) - 8);
         default: return $urandom;
      endcase
   endfunction

   // Once values exist, half of the search keys are taken from the values already inserted.
   function automatic logic signed [DATA_W-1:0] pick_key();
      if (inserted_values.size() != 0 && $urandom_range(0, 1))
         return inserted_values[$urandom_range(0, inserted_values.size() - 1)];
      return pick_value();
   endfunction

   task automatic add_item(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] value);
      list_command_type item;
      item.cmd = cmd;
      item.value = value;
      item.drain_before = drain_next;
      drain_next = 1'b0;
      if (burst_mode) begin
         item.gap_after = 0;
      end else begin
         case ($urandom_range(0, 19))
            12, 13, 14, 15, 16, 17: item.gap_after = $urandom_range(1, 3);
            18, 19: item.gap_after = $urandom_range(20, 80);
            default: item.gap_after = 0;
         endcase
      end
      if (cmd == CMD_INSERT) inserted_values.push_back(value);
      if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) random_items++;
      commands_to_send.push_back(item);
   endtask

   // Driver: presents the next item once the previous is taken, any gap over and any drain done.
   always @(posedge clock) begin
      list_command_type nxt;
      if (reset) begin
         start <= 1'b0;
         send_wait <= 0;
      end else if (!start || !busy) begin
         if (send_wait != 0) begin
            start <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (commands_to_send.size() == 0) begin
            start <= 1'b0;
         end else if (commands_to_send[0].drain_before &&
                      (start || busy || results_due.size() != 0)) begin
            start <= 1'b0;
         end else begin
            nxt = commands_to_send.pop_front();
            start <= 1'b1;
            req_cmd <= nxt.cmd;
            req_item_value <= nxt.value;
            send_wait <= nxt.gap_after;
         end
      end
   end

   // Monitor: predicts each accepted item, then checks any result shown in this cycle.
   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (!reset) begin
         if (start && !busy) apply_list_command(req_cmd, req_item_value);
         if (rsp_valid) begin
            got = '{status: rsp_status, found: rsp_found, position: rsp_position,
                    entry_value: rsp_entry_value, last: rsp_last};
            if (results_due.size() == 0) begin
               report_mismatch("result with none expected, entry_value", '0, got.entry_value);
            end else begin
               want = results_due.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", want.status, got.status);
               if (got.found !== want.found)
                  report_mismatch("found", want.found, got.found);
               if (got.position !== want.position)
                  report_mismatch("position", want.position, got.position);
               if (got.entry_value !== want.entry_value)
                  report_mismatch("entry_value", want.entry_value, got.entry_value);
               if (got.last !== want.last)
                  report_mismatch("last", want.last, got.last);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int n;
      // Directed part: empty list cases, extremes, every command and the spare codes.
      add_item(CMD_READ, '0);
      add_item(CMD_SEARCH, VALUE_MAX);
      add_item(CMD_SORT_UP, '0);
      add_item(CMD_SORT_DOWN, '0);
      add_item(CMD_INSERT, VALUE_MAX);
      add_item(CMD_SORT_UP, '0);
      add_item(CMD_INSERT, VALUE_MIN);
      add_item(CMD_INSERT, '0);
      add_item(CMD_INSERT, '1);
      add_item(CMD_INSERT, 32'sd1);
      add_item(CMD_INSERT, '0);
      add_item(CMD_SEARCH, VALUE_MIN);
      add_item(CMD_SEARCH, '0);
      add_item(CMD_SEARCH, 32'sd12345);
      add_item(CMD_SORT_UP, '0);
      add_item(CMD_READ, '0);
      add_item(CMD_SORT_DOWN, '0);
      add_item(CMD_READ, '0);
      add_item(CMD_SPARE_LO, VALUE_MAX);
      add_item(CMD_SPARE_HI, VALUE_MIN);
      add_item(CMD_READ, '0);
      add_item(CMD_CLEAR, '0);
      add_item(CMD_READ, '0);

      // Random part: mostly whole list sessions, some of them filling past full, plus noise.
      random_items = 0;
      drain_next = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) drain_next = 1'b1;
         case ($urandom_range(0, 5))
            0: begin
               add_item(CMD_CLEAR, pick_value());
               n = LIST_DEPTH + $urandom_range(1, 3);
               repeat (n) add_item(CMD_INSERT, pick_value());
               add_item(CMD_SEARCH, pick_key());
               add_item($urandom_range(0, 1) ? CMD_SORT_UP : CMD_SORT_DOWN, pick_value());
               add_item(CMD_READ, pick_value());
               add_item(CMD_SEARCH, pick_key());
            end
            1, 2, 3: begin
               if ($urandom_range(0, 1)) add_item(CMD_CLEAR, pick_value());
               n = $urandom_range(1, 8);
               repeat (n) add_item(CMD_INSERT, pick_value());
               add_item(CMD_SEARCH, pick_key());
               add_item($urandom_range(0, 1) ? CMD_SORT_UP : CMD_SORT_DOWN, pick_value());
               add_item(CMD_READ, pick_value());
               add_item(CMD_SEARCH, pick_key());
            end
            default: begin
               n = $urandom_range(3, 8);
               repeat (n) add_item(CMD_W'($urandom_range(0, 7)), pick_value());
            end
         endcase
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for the stimulus to drain and every expected result to arrive.
      @(posedge clock);
      while (commands_to_send.size() != 0 || start || busy || results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (results_due.size() != 0)
         report_mismatch("results never received, count", '0, results_due.size());
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
